@@ sv/nsh_pkg.sv @@
// Package for the iterated salted SHA-1 name hash core.
// Holds payload structs, register codes and SHA-1 constants; no dependencies.
package nsh_pkg;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       final_byte;
    } nsh_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        run_end;
        logic        too_long;
    } nsh_out_t;

    localparam logic [1:0] REG_SALT_VALUE  = 2'd0;
    localparam logic [1:0] REG_SALT_LENGTH = 2'd1;
    localparam logic [1:0] REG_EXTRA_ITER  = 2'd2;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    // Request to the compression unit and its status back.
    typedef struct packed {
        logic start;
        logic init;
    } nsh_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } nsh_sts_t;

endpackage

@@ sv/nsh_compress.sv @@
// SHA-1 compression unit: one round per clock over a 16-word schedule window.
// Depends on nsh_pkg.
module nsh_compress (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nsh_pkg::nsh_cmd_t    cmd,
    input  logic [511:0]         block,
    output nsh_pkg::nsh_sts_t    sts,
    output logic [159:0]         chain
);
    import nsh_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] h_reg [5];
    logic [6:0]  rnd_reg;
    logic        busy_reg, done_reg;

    logic [31:0] wx, w_cur, f, k, tmp;

    always_comb begin
        wx = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        wx = {wx[30:0], wx[31]};
        w_cur = (rnd_reg < 7'd16) ? w_reg[0] : wx;
        if (rnd_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end else if (rnd_reg < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end else if (rnd_reg < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
            h_reg[3] <= IV3; h_reg[4] <= IV4;
        end else begin
            done_reg <= busy_reg && (rnd_reg == 7'd80);
            if (cmd.init) begin
                h_reg[0] <= IV0; h_reg[1] <= IV1; h_reg[2] <= IV2;
                h_reg[3] <= IV3; h_reg[4] <= IV4;
            end
            if (cmd.start && !busy_reg) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                for (int i = 0; i < 16; i++) begin
                    w_reg[i] <= block[511-32*i -: 32];
                end
                a_reg <= cmd.init ? IV0 : h_reg[0];
                b_reg <= cmd.init ? IV1 : h_reg[1];
                c_reg <= cmd.init ? IV2 : h_reg[2];
                d_reg <= cmd.init ? IV3 : h_reg[3];
                e_reg <= cmd.init ? IV4 : h_reg[4];
            end else if (busy_reg) begin
                if (rnd_reg == 7'd80) begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                    busy_reg <= 1'b0;
                end else begin
                    // The window shifts by one word each round.
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_cur;
                    e_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    b_reg <= a_reg;
                    a_reg <= tmp;
                    rnd_reg <= rnd_reg + 7'd1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign chain = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

endmodule

@@ sv/iterated_salted_sha1_name_hash_core.sv @@
// Top level of the iterated salted SHA-1 name hash core.
// Depends on nsh_pkg and nsh_compress.
//
//  channel | ports              | meaning
//  s_      | s_valid/s_ready    | one name byte per transfer, final_byte marks the end
//  m_      | m_valid/m_ready    | five digest words, or one error word
//  apb     | psel..prdata       | salt value, salt length, extra iterations
//
// A non-final byte that completes a 64-byte block starts a compression.
// The last byte then adds the salt and padding bytes, one per cycle, stopping for each
// block compressed; each extra iteration adds salt, padding and one compression. The
// shared compression unit (one round a cycle) does every compression.
// Reset is synchronous and active low. Results wait in an output register under
// m_ready back-pressure; no input is taken until the last result has gone.
module iterated_salted_sha1_name_hash_core #(
    parameter int SALT_BYTES     = 8,
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nsh_pkg::nsh_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nsh_pkg::nsh_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    import nsh_pkg::*;

    localparam int SALT_CAP = (SALT_BYTES < 8) ? SALT_BYTES : 8;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COMP  = 7'b0000010,
        ST_SALT  = 7'b0000100,
        ST_PAD   = 7'b0001000,
        ST_LOAD  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    state_t       state_reg;
    logic [63:0]  salt_value_reg;
    logic [3:0]   salt_length_reg;
    logic [11:0]  extra_iter_reg;
    logic [63:0]  salt_run_reg;
    logic [63:0]  salt_keep_reg;
    logic [3:0]   salt_n_reg, salt_i_reg;
    logic [11:0]  iter_reg;
    logic [511:0] buf_reg;
    logic [8:0]   pos_reg;     // bytes placed in current message
    logic [8:0]   total_reg;   // name bytes accepted
    logic         over_reg;
    logic [63:0]  bits_reg;
    logic [2:0]   last_blk_reg;
    logic [8:0]   pad_end;
    logic         finishing_reg, init_reg;
    logic [2:0]   widx_reg;
    logic         err_reg;
    state_t       after_reg;
    nsh_cmd_t     cmd_reg, cmd_next;
    nsh_sts_t     sts;
    logic [159:0] chain;
    logic [1:0]   ridx;

    nsh_compress u_comp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd_reg), .block(buf_reg),
        .sts(sts), .chain(chain)
    );

    assign ridx   = paddr[4:3];
    assign pready = 1'b1;
    always_comb begin
        case (ridx)
            REG_SALT_VALUE:  prdata = salt_value_reg;
            REG_SALT_LENGTH: prdata = {60'd0, salt_length_reg};
            REG_EXTRA_ITER:  prdata = {52'd0, extra_iter_reg};
            default:         prdata = '0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // The length field fills the last eight bytes of the block that holds the end
    // of the message plus eight bytes.
    assign pad_end = pos_reg + 9'd8;

    logic [7:0] pad_byte;
    always_comb begin
        if (!finishing_reg) pad_byte = 8'h80;
        else if (pos_reg[8:6] == last_blk_reg && pos_reg[5:0] >= 6'd56)
            pad_byte = bits_reg[8*(63-pos_reg[5:0]) +: 8];
        else pad_byte = 8'h00;
    end

    // Request a compression when the byte written fills a block; ST_WAIT resets the chain.
    always_comb begin
        cmd_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && !over_reg && total_reg < 9'(MAX_NAME_BYTES) &&
                    pos_reg[5:0] == 6'd63) begin
                    cmd_next.start = 1'b1;
                    cmd_next.init  = init_reg;
                end
            end
            ST_SALT: begin
                if (salt_i_reg != salt_n_reg && pos_reg[5:0] == 6'd63) begin
                    cmd_next.start = 1'b1;
                    cmd_next.init  = init_reg;
                end
            end
            ST_PAD: begin
                if (pos_reg[5:0] == 6'd63) begin
                    cmd_next.start = 1'b1;
                    cmd_next.init  = init_reg;
                end
            end
            ST_WAIT: cmd_next.init = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            salt_value_reg  <= '0;
            salt_length_reg <= '0;
            extra_iter_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_SALT_VALUE:  salt_value_reg  <= pwdata;
                REG_SALT_LENGTH: salt_length_reg <= pwdata[3:0];
                REG_EXTRA_ITER:  extra_iter_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg <= '0;
            total_reg <= '0;
            pos_reg <= '0;
            over_reg <= 1'b0;
            finishing_reg <= 1'b0;
            init_reg <= 1'b1;
            widx_reg <= '0;
            err_reg <= 1'b0;
            iter_reg <= '0;
            salt_i_reg <= '0;
            salt_n_reg <= '0;
            last_blk_reg <= '0;
            after_reg <= ST_IDLE;
        end else begin
            cmd_reg <= cmd_next;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (!over_reg) begin
                            if (total_reg >= 9'(MAX_NAME_BYTES)) begin
                                over_reg <= 1'b1;
                            end else begin
                                buf_reg[8*(63-pos_reg[5:0]) +: 8] <= s_data.name_byte;
                                total_reg <= total_reg + 9'd1;
                                pos_reg <= pos_reg + 9'd1;
                            end
                        end
                        if (s_data.final_byte) begin
                            salt_run_reg <= salt_value_reg;
                            salt_keep_reg <= salt_value_reg;
                            salt_n_reg <= (salt_length_reg > 4'(SALT_CAP)) ?
                                          4'(SALT_CAP) : salt_length_reg;
                            salt_i_reg <= '0;
                            iter_reg <= extra_iter_reg;
                        end
                        if (s_data.final_byte &&
                            (over_reg || total_reg >= 9'(MAX_NAME_BYTES))) begin
                            err_reg <= 1'b1;
                            widx_reg <= '0;
                            state_reg <= ST_OUT;
                        end else if (!over_reg && total_reg < 9'(MAX_NAME_BYTES) &&
                                     pos_reg[5:0] == 6'd63) begin
                            init_reg <= 1'b0;
                            after_reg <= s_data.final_byte ? ST_SALT : ST_IDLE;
                            state_reg <= ST_COMP;
                        end else if (s_data.final_byte) begin
                            state_reg <= ST_SALT;
                        end
                    end
                end
                ST_COMP: begin
                    if (sts.done) state_reg <= after_reg;
                end
                ST_SALT: begin
                    if (salt_i_reg == salt_n_reg) begin
                        bits_reg <= {52'd0, pos_reg, 3'd0};
                        last_blk_reg <= pad_end[8:6];
                        finishing_reg <= 1'b0;
                        state_reg <= ST_PAD;
                    end else begin
                        buf_reg[8*(63-pos_reg[5:0]) +: 8] <= salt_run_reg[63:56];
                        salt_run_reg <= {salt_run_reg[55:0], 8'd0};
                        salt_i_reg <= salt_i_reg + 4'd1;
                        pos_reg <= pos_reg + 9'd1;
                        if (pos_reg[5:0] == 6'd63) begin
                            init_reg <= 1'b0;
                            after_reg <= ST_SALT;
                            state_reg <= ST_COMP;
                        end
                    end
                end
                ST_PAD: begin
                    buf_reg[8*(63-pos_reg[5:0]) +: 8] <= pad_byte;
                    finishing_reg <= 1'b1;
                    pos_reg <= pos_reg + 9'd1;
                    if (pos_reg[5:0] == 6'd63) begin
                        init_reg <= 1'b0;
                        // The block that carries the length field ends the message.
                        after_reg <= (pos_reg[8:6] == last_blk_reg) ? ST_LOAD : ST_PAD;
                        state_reg <= ST_COMP;
                    end
                end
                ST_LOAD: begin
                    if (iter_reg == '0) begin
                        widx_reg <= '0;
                        err_reg <= 1'b0;
                        state_reg <= ST_OUT;
                    end else begin
                        // The previous digest becomes the next message.
                        iter_reg <= iter_reg - 12'd1;
                        buf_reg[511:352] <= chain;
                        pos_reg <= 9'd20;
                        init_reg <= 1'b1;
                        salt_run_reg <= salt_keep_reg;
                        salt_i_reg <= '0;
                        state_reg <= ST_SALT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (err_reg || widx_reg == 3'd4) begin
                            state_reg <= ST_WAIT;
                        end else begin
                            widx_reg <= widx_reg + 3'd1;
                        end
                    end
                end
                ST_WAIT: begin
                    init_reg <= 1'b1;
                    total_reg <= '0;
                    pos_reg <= '0;
                    over_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        m_data.digest_word = err_reg ? 32'd0 : chain[159-32*widx_reg -: 32];
        m_data.word_index  = err_reg ? 3'd0 : widx_reg;
        m_data.run_end     = err_reg || (widx_reg == 3'd4);
        m_data.too_long    = err_reg;
    end

endmodule

@@ sv/nsh_checker.sv @@
// Port-level checks for the name hash core, bound to the top level.
// Depends on nsh_pkg.
module nsh_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input nsh_pkg::nsh_out_t m_data
);
    import nsh_pkg::*;

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and output both open");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.too_long |-> m_data.run_end && m_data.digest_word == 32'd0)
        else $error("bad error result");
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.run_end |=> !m_valid) else $error("extra result");
endmodule

bind iterated_salted_sha1_name_hash_core nsh_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
